// ----- src/clff_pkg.sv -----
// Shared types and constants for the CRLF line framer.
package clff_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Drop pattern "0.0000 kg", oldest byte first.
    localparam int PAT_LEN   = 9;
    localparam int PAT_CNT_W = 4;
    localparam logic [7:0] DROP_PATTERN [0:PAT_LEN-1] = '{
        8'h30, 8'h2E, 8'h30, 8'h30, 8'h30, 8'h30, 8'h20, 8'h6B, 8'h67
    };

    typedef struct packed {
        logic store;       // write rx byte into line buffer
        logic start_scan;  // line end seen: begin scan at entry 0
        logic scan_step;   // advance the scan one entry; fill resets when the scan ends
        logic emit_byte;   // load buffered byte into output register
        logic emit_cr;     // load CR into output register
        logic emit_lf;     // load closing LF into output register
    } cmd_t;

    typedef struct packed {
        logic line_end;    // rx byte is LF and byte before fill is CR
        logic scan_done;   // scan reached first zero or fill
        logic match;       // drop pattern found in line
        logic len_zero;    // scan ended at entry 0
        logic at_last;     // emit index is on last line byte
        logic out_free;    // output register can take a word
    } sts_t;

endpackage

// ----- src/crlf_line_framer_with_filter_unit.sv -----
// Top level of the CRLF line framer with drop filter.
//
//  channel  direction  handshake           payload
//  rx       in         rx_valid/rx_stall   rx_byte[7:0]
//  tx       out        tx_valid/tx_stall   tx_byte[7:0], last_of_line
//
// An ordinary rx word is taken and written into the line buffer.
// A word that closes a line (LF after CR) starts a scan of the buffer memory,
// one entry per cycle; rx_stall is high meanwhile.
// Unless the line holds "0.0000 kg", len+2 tx words then follow at one per
// cycle while tx_stall is low, through a single output register, which tx_stall holds in place.
// Reset clears the controller, fill index and output valid; the buffer is not
// cleared, only entries written since the last line end are ever read.
module crlf_line_framer_with_filter_unit
#(
    parameter int DEPTH = 24
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       last_of_line
);

    // Commands from the controller, status back from the datapath.
    clff_pkg::cmd_t cmd;
    clff_pkg::sts_t sts;

    clff_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Buffer memory, scan window and output register live here.
    clff_datapath #(.DEPTH(DEPTH)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .tx_valid     (tx_valid),
        .tx_stall     (tx_stall),
        .tx_byte      (tx_byte),
        .last_of_line (last_of_line)
    );

endmodule

// ----- src/clff_ctrl.sv -----
// Controller state machine for the CRLF line framer.
module clff_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rx_valid,
    output logic           rx_stall,
    input  clff_pkg::sts_t sts,
    output clff_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_EMIT = 3'd2;
    localparam logic [2:0] ST_CR   = 3'd3;
    localparam logic [2:0] ST_LF   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    if (sts.line_end)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.match)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (sts.len_zero)
                    begin
                        state_next = ST_CR;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (sts.at_last)
                    begin
                        state_next = ST_CR;
                    end
                end
            end
            ST_CR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_cr = 1'b1;
                    state_next  = ST_LF;
                end
            end
            ST_LF:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_lf = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/clff_datapath.sv -----
// Datapath for the CRLF line framer: line buffer, scan, pattern window, output register.
module clff_datapath
#(
    parameter int DEPTH = 24
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     rx_byte,
    input  clff_pkg::cmd_t cmd,
    output clff_pkg::sts_t sts,
    output logic           tx_valid,
    input  logic           tx_stall,
    output logic [7:0]     tx_byte,
    output logic           last_of_line
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] FILL_MAX = IW'(DEPTH - 1);

    logic [7:0]    mem [0:DEPTH-1];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_addr;

    logic [IW-1:0] fill_reg;
    logic [7:0]    prev_reg;    // copy of the entry just below fill
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [IW-1:0] len_reg;

    logic [7:0]                   win_reg  [0:clff_pkg::PAT_LEN-1];
    logic [7:0]                   win_next [0:clff_pkg::PAT_LEN-1];
    logic [clff_pkg::PAT_CNT_W-1:0] cnt_reg;
    logic [clff_pkg::PAT_CNT_W-1:0] cnt_next;
    logic                         match_reg;
    logic                         win_hit;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_load;

    // Status
    always_comb
    begin
        sts.line_end  = (rx_byte == clff_pkg::CH_LF) && (fill_reg != '0)
                        && (prev_reg == clff_pkg::CH_CR);
        sts.scan_done = (idx_reg == fill_reg) || (rd_data_reg == 8'h00);
        sts.match     = match_reg;
        sts.len_zero  = (idx_reg == '0);
        sts.at_last   = ((idx_reg + IW'(1)) == len_reg);
        sts.out_free  = !out_valid_reg || !tx_stall;
    end

    // Scan / emit index; the read address runs one step ahead so that
    // rd_data_reg holds mem[idx_reg] during the scan and the emit.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start_scan)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = sts.scan_done ? '0 : idx_reg + IW'(1);
        end
        else if (cmd.emit_byte)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    assign rd_addr = idx_next;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[fill_reg] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Pattern window: newest byte at the top.
    always_comb
    begin
        for (int k = 0; k < clff_pkg::PAT_LEN - 1; k++)
        begin
            win_next[k] = win_reg[k+1];
        end
        win_next[clff_pkg::PAT_LEN-1] = rd_data_reg;
        cnt_next = (cnt_reg == clff_pkg::PAT_CNT_W'(clff_pkg::PAT_LEN))
                   ? cnt_reg : cnt_reg + clff_pkg::PAT_CNT_W'(1);
        win_hit = (cnt_next == clff_pkg::PAT_CNT_W'(clff_pkg::PAT_LEN));
        for (int k = 0; k < clff_pkg::PAT_LEN; k++)
        begin
            if (win_next[k] != clff_pkg::DROP_PATTERN[k])
            begin
                win_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && !sts.scan_done)
        begin
            for (int k = 0; k < clff_pkg::PAT_LEN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
        if (cmd.scan_step && sts.scan_done)
        begin
            len_reg <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            prev_reg  <= 8'h00;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.store && (fill_reg != FILL_MAX))
            begin
                // at saturation the last slot is overwritten, entry below stays
                fill_reg <= fill_reg + IW'(1);
                prev_reg <= rx_byte;
            end
            // fill bounds the scan, so it clears only once the scan ends
            if (cmd.scan_step && sts.scan_done)
            begin
                fill_reg <= '0;
            end
            if (cmd.start_scan)
            begin
                cnt_reg   <= '0;
                match_reg <= 1'b0;
            end
            else if (cmd.scan_step && !sts.scan_done)
            begin
                cnt_reg <= cnt_next;
                if (win_hit)
                begin
                    match_reg <= 1'b1;
                end
            end
        end
    end

    // Output register
    assign out_load = cmd.emit_byte || cmd.emit_cr || cmd.emit_lf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!tx_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= cmd.emit_byte ? rd_data_reg
                          : (cmd.emit_cr ? clff_pkg::CH_CR : clff_pkg::CH_LF);
            out_last_reg <= cmd.emit_lf;
        end
    end

    assign tx_valid     = out_valid_reg;
    assign tx_byte      = out_byte_reg;
    assign last_of_line = out_last_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill index beyond last slot");

    a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && sts.scan_done) |=> (fill_reg == '0))
        else $error("fill index not cleared at line end");

    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && last_of_line) |-> (tx_byte == clff_pkg::CH_LF))
        else $error("line end flag on a word other than LF");

    a_no_load_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && tx_stall) |-> !out_load)
        else $error("output register overwritten while stalled");
`endif

endmodule
